[design/ebt_pkg.sv]
// Package for the elevator bank tick controller.
// Holds sizes, mark and heading codes, the sequencer state type and the
// configuration struct shared by all modules of the block.
package ebt_pkg;

   localparam int CARS      = 6;
   localparam int FLOORS    = 20;
   localparam int CAR_W     = 3;
   localparam int FLOOR_W   = 5;
   localparam int DOOR_W    = 4;
   localparam int HEADING_W = 2;
   localparam int CNT_W     = $clog2(FLOORS + 1);
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_DOOR_WAIT   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_REQUEST_CAR = CSR_IDX_W'(1);

   localparam logic [DOOR_W-1:0] DOOR_WAIT_RESET   = DOOR_W'(2);
   localparam logic [CAR_W-1:0]  REQUEST_CAR_RESET = CAR_W'(1);

   localparam logic ACT_TICK    = 1'b0;
   localparam logic ACT_REQUEST = 1'b1;

   typedef enum logic [1:0] {
      MARK_NONE   = 2'd0,
      MARK_DEST   = 2'd1,
      MARK_PICKUP = 2'd2
   } mark_type;

   typedef mark_type [FLOORS-1:0] mark_row_type;

   typedef enum logic [HEADING_W-1:0] {
      HEAD_IDLE = 2'd0,
      HEAD_UP   = 2'd1,
      HEAD_DOWN = 2'd2
   } heading_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_REPORT
   } state_type;

   typedef struct packed {
      logic [DOOR_W-1:0] door_wait;
      logic [CAR_W-1:0]  request_car;
   } cfg_type;

endpackage

[design/elevator_bank_tick_controller_unit.sv]
// Top level of the elevator bank tick controller: sequencer, per-car state,
// output register. Depends on ebt_pkg, ebt_csr and ebt_scan.
//
//   channel | direction | handshake          | words per item
//   req_    | in        | req_valid/req_stall | 1 (tick or travel request)
//   rsp_    | out       | rsp_valid/rsp_stall | 6 (one status word per car)
//   csr_    | in        | csr_valid/csr_ready | 1 register write
//
// On a tick each car gets an update state and then a report state, and both
// share the one direction unit; a request writes its marks, then reports each car.
// Reset is synchronous and clears all cars to floor zero with no marks.
// A stalled output word holds the sequencer in its report cycle; a new item
// is taken as soon as the last status word sits in the output register.
module elevator_bank_tick_controller_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_action,
   input  logic [ebt_pkg::FLOOR_W-1:0]    req_from_floor,
   input  logic [ebt_pkg::FLOOR_W-1:0]    req_to_floor,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [ebt_pkg::CAR_W-1:0]      rsp_car_index,
   output logic [ebt_pkg::FLOOR_W-1:0]    rsp_car_floor,
   output logic [ebt_pkg::HEADING_W-1:0]  rsp_heading,
   output logic [ebt_pkg::DOOR_W-1:0]     rsp_door_count,
   output logic                           rsp_occupied,
   output logic                           rsp_last_car,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [ebt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ebt_pkg::CSR_DATA_W-1:0] csr_data
);

   localparam logic [ebt_pkg::CAR_W-1:0]   LAST_CAR  = ebt_pkg::CAR_W'(ebt_pkg::CARS - 1);
   localparam logic [ebt_pkg::FLOOR_W-1:0] TOP_FLOOR =
      ebt_pkg::FLOOR_W'(ebt_pkg::FLOORS - 1);

   ebt_pkg::cfg_type cfg;

   ebt_pkg::state_type state_ff, state_in;
   logic [ebt_pkg::CAR_W-1:0] car_ff, car_in;
   logic tick_ff, tick_in;

   ebt_pkg::mark_row_type        marks_ff [ebt_pkg::CARS];
   logic [ebt_pkg::FLOOR_W-1:0]  pos_ff   [ebt_pkg::CARS];
   logic                         occ_ff   [ebt_pkg::CARS];
   logic [ebt_pkg::DOOR_W-1:0]   door_ff  [ebt_pkg::CARS];

   logic rsp_valid_ff, rsp_valid_in;
   logic [ebt_pkg::CAR_W-1:0]     rsp_car_ff;
   logic [ebt_pkg::FLOOR_W-1:0]   rsp_floor_ff;
   ebt_pkg::heading_type          rsp_heading_ff;
   logic [ebt_pkg::DOOR_W-1:0]    rsp_door_ff;
   logic                          rsp_occ_ff;
   logic                          rsp_last_ff;

   logic accept;
   logic out_free;
   logic load_out;
   logic write_car;
   logic write_request;
   logic request_ok;

   logic [ebt_pkg::FLOOR_W-1:0] cur_pos;
   ebt_pkg::mark_row_type       cur_row;
   ebt_pkg::mark_type           cur_mark;
   logic                        occ_set;
   logic                        serve;
   ebt_pkg::mark_row_type       row_in;
   logic [ebt_pkg::FLOOR_W-1:0] pos_in;
   logic                        occ_in;
   logic [ebt_pkg::DOOR_W-1:0]  door_in;
   ebt_pkg::mark_row_type       req_row_in;

   ebt_pkg::mark_row_type       scan_row;
   ebt_pkg::heading_type        scan_heading;

   ebt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   ebt_scan u_scan (
      .row     (scan_row),
      .cur     (cur_pos),
      .heading (scan_heading)
   );

   assign req_stall = (state_ff != ebt_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Tick update of the car under the sequencer. The served mark is cleared
   // before the direction rule looks at the row.
   always_comb begin
      cur_pos  = pos_ff[car_ff];
      cur_row  = marks_ff[car_ff];
      cur_mark = cur_row[cur_pos];
      occ_set  = occ_ff[car_ff] || (cur_mark == ebt_pkg::MARK_PICKUP);
      serve    = (cur_mark != ebt_pkg::MARK_NONE) && occ_set;
      row_in   = cur_row;
      door_in  = door_ff[car_ff];
      if (serve) begin
         row_in[cur_pos] = ebt_pkg::MARK_NONE;
         door_in         = cfg.door_wait;
      end
      scan_row = (state_ff == ebt_pkg::ST_UPDATE) ? row_in : cur_row;
      pos_in   = cur_pos;
      occ_in   = occ_set;
      if (door_in == '0) begin
         case (scan_heading)
            ebt_pkg::HEAD_UP: begin
               if (cur_pos != TOP_FLOOR) begin
                  pos_in = cur_pos + ebt_pkg::FLOOR_W'(1);
               end
            end
            ebt_pkg::HEAD_DOWN: begin
               if (cur_pos != '0) begin
                  pos_in = cur_pos - ebt_pkg::FLOOR_W'(1);
               end
            end
            ebt_pkg::HEAD_IDLE: begin
               occ_in = 1'b0;
            end
            default: begin
               pos_in = cur_pos;
            end
         endcase
      end else begin
         door_in = door_in - ebt_pkg::DOOR_W'(1);
      end
   end

   // Travel request: pickup mark first, destination second.
   always_comb begin
      request_ok = (req_from_floor < ebt_pkg::FLOOR_W'(ebt_pkg::FLOORS))
                && (req_to_floor < ebt_pkg::FLOOR_W'(ebt_pkg::FLOORS))
                && (req_from_floor != req_to_floor)
                && (cfg.request_car < ebt_pkg::CAR_W'(ebt_pkg::CARS));
      req_row_in = marks_ff[cfg.request_car];
      req_row_in[req_from_floor] = ebt_pkg::MARK_PICKUP;
      req_row_in[req_to_floor]   = ebt_pkg::MARK_DEST;
   end

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      car_in        = car_ff;
      tick_in       = tick_ff;
      load_out      = 1'b0;
      write_car     = 1'b0;
      write_request = 1'b0;
      case (state_ff)
         ebt_pkg::ST_IDLE: begin
            if (accept) begin
               car_in  = '0;
               tick_in = (req_action == ebt_pkg::ACT_TICK);
               if (req_action == ebt_pkg::ACT_TICK) begin
                  state_in = ebt_pkg::ST_UPDATE;
               end else begin
                  write_request = request_ok;
                  state_in      = ebt_pkg::ST_REPORT;
               end
            end
         end
         ebt_pkg::ST_UPDATE: begin
            write_car = 1'b1;
            state_in  = ebt_pkg::ST_REPORT;
         end
         ebt_pkg::ST_REPORT: begin
            if (out_free) begin
               load_out = 1'b1;
               if (car_ff == LAST_CAR) begin
                  state_in = ebt_pkg::ST_IDLE;
               end else begin
                  car_in   = car_ff + ebt_pkg::CAR_W'(1);
                  state_in = tick_ff ? ebt_pkg::ST_UPDATE : ebt_pkg::ST_REPORT;
               end
            end
         end
         default: begin
            state_in = ebt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ebt_pkg::ST_IDLE;
         car_ff   <= '0;
         tick_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         car_ff   <= car_in;
         tick_ff  <= tick_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < ebt_pkg::CARS; c++) begin
            marks_ff[c] <= '{default: ebt_pkg::MARK_NONE};
            pos_ff[c]   <= '0;
            occ_ff[c]   <= 1'b0;
            door_ff[c]  <= '0;
         end
      end else if (write_car) begin
         marks_ff[car_ff] <= row_in;
         pos_ff[car_ff]   <= pos_in;
         occ_ff[car_ff]   <= occ_in;
         door_ff[car_ff]  <= door_in;
      end else if (write_request) begin
         marks_ff[cfg.request_car] <= req_row_in;
      end
   end

   assign rsp_valid_in = load_out || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_car_ff     <= car_ff;
         rsp_floor_ff   <= cur_pos;
         rsp_heading_ff <= scan_heading;
         rsp_door_ff    <= door_ff[car_ff];
         rsp_occ_ff     <= occ_ff[car_ff];
         rsp_last_ff    <= (car_ff == LAST_CAR);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_car_index  = rsp_car_ff;
   assign rsp_car_floor  = rsp_floor_ff;
   assign rsp_heading    = rsp_heading_ff;
   assign rsp_door_count = rsp_door_ff;
   assign rsp_occupied   = rsp_occ_ff;
   assign rsp_last_car   = rsp_last_ff;

endmodule

[design/ebt_csr.sv]
// Configuration registers of the elevator bank tick controller.
// Depends on ebt_pkg for register indexes, widths and the cfg_type struct.
module ebt_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [ebt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ebt_pkg::CSR_DATA_W-1:0] csr_data,
   output ebt_pkg::cfg_type               cfg
);

   ebt_pkg::cfg_type cfg_ff;
   ebt_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            ebt_pkg::CSR_DOOR_WAIT: begin
               cfg_in.door_wait = csr_data[ebt_pkg::DOOR_W-1:0];
            end
            ebt_pkg::CSR_REQUEST_CAR: begin
               cfg_in.request_car = csr_data[ebt_pkg::CAR_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.door_wait   <= ebt_pkg::DOOR_WAIT_RESET;
         cfg_ff.request_car <= ebt_pkg::REQUEST_CAR_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[design/ebt_scan.sv]
// Shared direction unit: scans one car's row of stop marks in parallel and
// applies the direction rule. Depends on ebt_pkg for mark and heading codes.
module ebt_scan (
   input  ebt_pkg::mark_row_type        row,
   input  logic [ebt_pkg::FLOOR_W-1:0]  cur,
   output ebt_pkg::heading_type         heading
);

   logic [ebt_pkg::FLOORS-1:0]  below_vec;
   logic [ebt_pkg::FLOORS-1:0]  above_vec;
   logic [ebt_pkg::FLOORS-1:0]  marked_vec;
   logic [ebt_pkg::FLOOR_W-1:0] target;
   logic [ebt_pkg::CNT_W-1:0]   below_cnt;
   logic [ebt_pkg::CNT_W-1:0]   above_cnt;

   always_comb begin
      target = cur;
      for (int f = 0; f < ebt_pkg::FLOORS; f++) begin
         marked_vec[f] = (row[f] != ebt_pkg::MARK_NONE);
         below_vec[f]  = marked_vec[f] && (ebt_pkg::FLOOR_W'(f) < cur);
         above_vec[f]  = marked_vec[f] && (ebt_pkg::FLOOR_W'(f) > cur);
         // The highest pickup floor wins, so later floors override.
         if (row[f] == ebt_pkg::MARK_PICKUP) begin
            target = ebt_pkg::FLOOR_W'(f);
         end
      end
   end

   assign below_cnt = ebt_pkg::CNT_W'($countones(below_vec));
   assign above_cnt = ebt_pkg::CNT_W'($countones(above_vec));

   always_comb begin
      if (marked_vec == '0) begin
         heading = ebt_pkg::HEAD_IDLE;
      end else if (target != cur) begin
         heading = (target > cur) ? ebt_pkg::HEAD_UP : ebt_pkg::HEAD_DOWN;
      end else if (below_cnt > above_cnt) begin
         heading = ebt_pkg::HEAD_DOWN;
      end else if (below_cnt < above_cnt) begin
         heading = ebt_pkg::HEAD_UP;
      end else begin
         heading = ebt_pkg::HEAD_IDLE;
      end
   end

endmodule
